[src/bbp_pkg.sv]
package bbp_pkg;

  localparam int INDEX_BITS_DEF = 10;

  localparam int CTR_BITS = 2;
  localparam logic [CTR_BITS-1:0] CTR_SNT = 2'd0;
  localparam logic [CTR_BITS-1:0] CTR_WNT = 2'd1;
  localparam logic [CTR_BITS-1:0] CTR_ST  = 2'd3;

  localparam int S_DATA_BITS = 40;
  localparam int M_DATA_BITS = 8;

  localparam logic REQ_PREDICT = 1'b0;
  localparam logic REQ_TRAIN   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_we;
    logic accept;
    logic commit;
  } bbp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } bbp_stat_t;

  function automatic logic [CTR_BITS-1:0] bump(input logic [CTR_BITS-1:0] ctr,
                                               input logic taken);
    logic [CTR_BITS-1:0] res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_ST) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_SNT) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

[src/bbp_ram.sv]
module bbp_ram import bbp_pkg::*; #(
  parameter int WIDTH = CTR_BITS,
  parameter int DEPTH = 1 << INDEX_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

[src/bbp_ctrl.sv]
module bbp_ctrl import bbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  bbp_stat_t stat,
  output bbp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        // wait until the output register can take the result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

[src/bbp_dp.sv]
module bbp_dp import bbp_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bbp_cmd_t               cmd,
  output bbp_stat_t              stat,
  input  logic [S_DATA_BITS-1:0] s_tdata,
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_DATA_BITS-1:0] m_tdata
);

  localparam int DEPTH = 1 << INDEX_BITS;

  logic [INDEX_BITS-1:0] clr_cnt;
  logic [INDEX_BITS-1:0] hist;
  logic [INDEX_BITS-1:0] pc_idx, bank_idx;
  logic                  train, outcome;
  logic                  pred_q;

  logic [INDEX_BITS-1:0] in_pc_idx;
  logic [INDEX_BITS-1:0] ch_rd_addr, bk_rd_addr;
  logic [CTR_BITS-1:0]   ch_rd, tk_rd, nt_rd, sel_ctr;
  logic                  choose_taken, pred, upd_choice;
  logic                  ch_we, tk_we, nt_we;
  logic [INDEX_BITS-1:0] ch_wr_addr, bk_wr_addr;
  logic [CTR_BITS-1:0]   ch_wr_data, bk_wr_data;

  assign in_pc_idx  = s_tdata[INDEX_BITS-1:0];
  assign ch_rd_addr = cmd.accept ? in_pc_idx : pc_idx;
  assign bk_rd_addr = cmd.accept ? (in_pc_idx ^ hist) : bank_idx;

  assign choose_taken = ch_rd[1];
  assign sel_ctr      = choose_taken ? tk_rd : nt_rd;
  assign pred         = sel_ctr[1];
  // choice is left alone when it pointed the wrong way but its bank was right
  assign upd_choice   = !((choose_taken != outcome) && (pred == outcome));

  always_comb begin
    ch_we      = 1'b0;
    tk_we      = 1'b0;
    nt_we      = 1'b0;
    ch_wr_addr = pc_idx;
    bk_wr_addr = bank_idx;
    ch_wr_data = bump(ch_rd, outcome);
    bk_wr_data = bump(sel_ctr, outcome);
    if (cmd.clr_we) begin
      ch_we      = 1'b1;
      tk_we      = 1'b1;
      nt_we      = 1'b1;
      ch_wr_addr = clr_cnt;
      bk_wr_addr = clr_cnt;
      ch_wr_data = CTR_WNT;
      bk_wr_data = CTR_WNT;
    end else if (cmd.commit && train == REQ_TRAIN) begin
      ch_we = upd_choice;
      tk_we = choose_taken;
      nt_we = !choose_taken;
    end
  end

  bbp_ram #(.WIDTH(CTR_BITS), .DEPTH(DEPTH)) u_choice (
    .clk(clk), .we(ch_we), .wr_addr(ch_wr_addr), .wr_data(ch_wr_data),
    .rd_addr(ch_rd_addr), .rd_data(ch_rd)
  );

  bbp_ram #(.WIDTH(CTR_BITS), .DEPTH(DEPTH)) u_taken (
    .clk(clk), .we(tk_we), .wr_addr(bk_wr_addr), .wr_data(bk_wr_data),
    .rd_addr(bk_rd_addr), .rd_data(tk_rd)
  );

  bbp_ram #(.WIDTH(CTR_BITS), .DEPTH(DEPTH)) u_not_taken (
    .clk(clk), .we(nt_we), .wr_addr(bk_wr_addr), .wr_data(bk_wr_data),
    .rd_addr(bk_rd_addr), .rd_data(nt_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      hist     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clr_we) clr_cnt <= clr_cnt + INDEX_BITS'(1);
      if (cmd.commit && train == REQ_TRAIN) hist <= {hist[INDEX_BITS-2:0], outcome};
      if (cmd.commit)    m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pc_idx   <= in_pc_idx;
      bank_idx <= in_pc_idx ^ hist;
      train    <= s_tuser;
      outcome  <= s_tdata[32];
    end
    if (cmd.commit) pred_q <= pred;
  end

  assign m_tdata       = {{(M_DATA_BITS-1){1'b0}}, pred_q};
  assign stat.clr_last = (clr_cnt == {INDEX_BITS{1'b1}});
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

[src/bimode_branch_predictor_top.sv]
// bi-mode branch predictor
// input channel s_*: one request per transfer. s_tuser is the request kind
// (0 predict only, 1 train), s_tdata carries pc in bits 31:0 and the resolved
// outcome in bit 32. every request gives exactly one result on m_*:
// m_tdata bit 0 is the predicted direction, taken before any training.
// a request is taken in the idle cycle, the counter tables are read out in
// the lookup state and the result is loaded into the output register at the
// end of a lookup cycle in which that register is free. each request is done
// before the next is taken: a registered read, then write-back on a train.
// results sit in a single output register; the block takes the next request
// while one waits there, and holds its write-back until that one is taken.
// after rst the three counter memories are swept to weakly not taken, one
// entry per cycle over all 2**INDEX_BITS entries, s_tready low throughout.
// the global history is cleared by rst.
module bimode_branch_predictor_top import bbp_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_DATA_BITS-1:0] s_tdata,  // pc[31:0], outcome[32], zero fill
  input  logic                   s_tuser,  // req_type
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_DATA_BITS-1:0] m_tdata   // prediction[0], zero fill
);

  bbp_cmd_t  cmd;
  bbp_stat_t stat;

  bbp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .stat(stat), .cmd(cmd)
  );

  bbp_dp #(.INDEX_BITS(INDEX_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

endmodule

[bench/bimode_branch_predictor_top_tb.sv]
`timescale 1ns / 1ps

module bimode_branch_predictor_top_tb import bbp_pkg::*;;

  localparam int IDX_W = INDEX_BITS_DEF;
  localparam int TBL_DEPTH = 1 << IDX_W;
  localparam int PHASE_ITEMS = 270;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic        req;
    logic [31:0] pc;
    logic        outcome;
    int          reps;
    logic        typed;
    logic        pred;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_DATA_BITS-1:0] s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_DATA_BITS-1:0] m_tdata;

  // predictor state
  logic [CTR_BITS-1:0] sel_ctr [TBL_DEPTH];
  logic [CTR_BITS-1:0] tk_ctr [TBL_DEPTH];
  logic [CTR_BITS-1:0] nt_ctr [TBL_DEPTH];
  logic [IDX_W-1:0]    ghist;

  logic pending_predictions[$];
  int   fail_count;
  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   hold_off_req;
  int   stall_cycles;

  dir_row_t    dir_rows[8];
  logic [31:0] hot_pc[16];
  int          hot_bias[16];

  bimode_branch_predictor_top #(
    .INDEX_BITS(IDX_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [CTR_BITS-1:0] sat_step(input logic [CTR_BITS-1:0] c,
                                                   input logic up);
    if (up) begin
      return (c == CTR_ST) ? c : c + CTR_BITS'(1);
    end
    return (c == CTR_SNT) ? c : c - CTR_BITS'(1);
  endfunction

  // direction before any update, then training when asked
  function automatic logic bimode_lookup_update(input logic rt, input logic [31:0] pc,
                                                input logic oc);
    logic [IDX_W-1:0] pidx;
    logic [IDX_W-1:0] bidx;
    logic             use_tk;
    logic             pred;
    pidx = pc[IDX_W-1:0];
    bidx = pidx ^ ghist;
    use_tk = sel_ctr[pidx][1];
    pred = use_tk ? tk_ctr[bidx][1] : nt_ctr[bidx][1];
    if (rt == REQ_TRAIN) begin
      if (use_tk) begin
        tk_ctr[bidx] = sat_step(tk_ctr[bidx], oc);
      end else begin
        nt_ctr[bidx] = sat_step(nt_ctr[bidx], oc);
      end
      // choice stays put when it disagreed but the chosen bank got it right
      if (!(use_tk != oc && pred == oc)) begin
        sel_ctr[pidx] = sat_step(sel_ctr[pidx], oc);
      end
      ghist = {ghist[IDX_W-2:0], oc};
    end
    return pred;
  endfunction

  task automatic send_request(input logic rt, input logic [31:0] pc, input logic oc,
                              input logic typed, input logic typed_pred);
    logic pred;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= rt;
    s_tdata  <= {{(S_DATA_BITS-33){1'b0}}, oc, pc};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = bimode_lookup_update(rt, pc, oc);
    pending_predictions.push_back(typed ? typed_pred : pred);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_predictions.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int n_items, input int hold_at);
    int          k;
    logic        rt;
    logic [31:0] pc;
    logic        oc;
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_off_req = 1'b1;
      if ($urandom_range(99) < 70) begin
        // hot branches with a per-branch bias, random upper pc bits
        k  = $urandom_range(15);
        pc = ($urandom & ~(32'(TBL_DEPTH) - 32'd1)) | (hot_pc[k] & (32'(TBL_DEPTH) - 32'd1));
        oc = ($urandom_range(99) < hot_bias[k]);
        rt = ($urandom_range(99) < 65) ? REQ_TRAIN : REQ_PREDICT;
      end else begin
        pc = $urandom;
        oc = $urandom_range(1);
        rt = $urandom_range(1) ? REQ_TRAIN : REQ_PREDICT;
      end
      send_request(rt, pc, oc, 1'b0, 1'b0);
    end
  endtask

  // result side
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      if (pending_predictions.size() == 0) begin
        $error("unexpected result: prediction %0d", m_tdata[0]);
        fail_count++;
      end else if (m_tdata[0] !== pending_predictions[0]) begin
        $error("prediction: expected %0d, actual %0d", pending_predictions[0], m_tdata[0]);
        fail_count++;
        void'(pending_predictions.pop_front());
      end else begin
        void'(pending_predictions.pop_front());
      end
    end
  end

  // watchdog on handshake progress, allows for the table clear after reset
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = REQ_PREDICT;
    fail_count = 0;
    hold_off_req = 1'b0;
    tx_idle_pct = 15;
    rx_idle_pct = 84;
    ghist = '0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      sel_ctr[i] = CTR_WNT;
      tk_ctr[i]  = CTR_WNT;
      nt_ctr[i]  = CTR_WNT;
    end
    for (int i = 0; i < 16; i++) begin
      hot_pc[i]   = $urandom;
      hot_bias[i] = (i < 4) ? 95 : (i < 8) ? 5 : $urandom_range(100);
    end

    // reset state reads weakly not taken everywhere; long taken then
    // not-taken runs on one branch drive counters into saturation
    dir_rows = '{
      '{REQ_PREDICT, 32'h0000_0000, 1'b0, 1,  1'b1, 1'b0},
      '{REQ_PREDICT, 32'hFFFF_FFFF, 1'b1, 1,  1'b1, 1'b0},
      '{REQ_PREDICT, 32'hFFFF_FC00, 1'b0, 1,  1'b1, 1'b0},
      '{REQ_TRAIN,   32'h0000_03A5, 1'b1, 1,  1'b1, 1'b0},
      '{REQ_TRAIN,   32'h0000_03A5, 1'b1, 11, 1'b0, 1'b0},
      '{REQ_PREDICT, 32'hABCD_03A5, 1'b0, 1,  1'b0, 1'b0},
      '{REQ_TRAIN,   32'h0000_03A5, 1'b0, 8,  1'b0, 1'b0},
      '{REQ_TRAIN,   32'h0000_005A, 1'b0, 1,  1'b0, 1'b0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      for (int j = 0; j < dir_rows[r].reps; j++) begin
        send_request(dir_rows[r].req, dir_rows[r].pc, dir_rows[r].outcome,
                     dir_rows[r].typed, dir_rows[r].pred);
      end
    end

    random_phase(PHASE_ITEMS, -1);
    wait_drained();

    tx_idle_pct = 84;
    rx_idle_pct = 15;
    random_phase(PHASE_ITEMS, -1);
    wait_drained();

    // no idling, with one long receiver hold-off part way through
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(PHASE_ITEMS, 20);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
